// ----- rtl/core/pngunf_pkg.sv -----
// shared constants, register indexes, filter type codes and the pipeline item type
// for the png scanline unfilter block; no dependencies
package pngunf_pkg;

  localparam int MAX_ROW_BYTES_DEF   = 4096;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  localparam int ROW_BYTES_W = 13;
  localparam int BPP_W       = 4;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_ADDR_W  = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_ROW_BYTES       = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_BYTES_PER_PIXEL = 1'b1;

  localparam logic [7:0] FT_NONE  = 8'd0;
  localparam logic [7:0] FT_SUB   = 8'd1;
  localparam logic [7:0] FT_UP    = 8'd2;
  localparam logic [7:0] FT_AVG   = 8'd3;
  localparam logic [7:0] FT_PAETH = 8'd4;

  // one byte on its way from the accept stage to the predictor
  typedef struct packed {
    logic [7:0] filt;
    logic [7:0] ftype;
    logic       first_row;
    logic       row_start;
    logic       has_left;
    logic       last;
  } pngunf_item_t;

endpackage

// ----- rtl/core/png_scanline_unfilter_top.sv -----
// path: accept stage with the row memory read, then the predictor into the output register
// throughput: one byte per cycle while out_tready is high; the previous-row memory read
// is registered in the first stage, the left-neighbor feedback closes inside the predictor
// reset (rst_n, synchronous): column 0, first row, registers row_bytes=1 and
// bytes_per_pixel=1, pipeline empty; the previous-row memory is not cleared
module png_scanline_unfilter_top #(
  parameter int MAX_ROW_BYTES   = pngunf_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = pngunf_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] filtered_byte
  input  logic [8:0]                        in_tuser,   // [7:0] filter_type, [8] image_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] raw_byte
  output logic                              out_tlast,
  output logic                              out_tuser,  // [0] type_error
  input  logic                              cfg_we,
  input  logic [pngunf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pngunf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import pngunf_pkg::*;

  localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int HIST_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int CMP_W  = ((COL_W > ROW_BYTES_W) ? COL_W : ROW_BYTES_W) + 1;

  logic [ROW_BYTES_W-1:0] row_bytes_r;
  logic [BPP_W-1:0]       bpp_r;

  logic [COL_W-1:0] column_r;
  logic             first_r;
  logic [7:0]       row_type_r;

  logic             s1_valid_r;
  pngunf_item_t     s1_item_r;
  logic [COL_W-1:0] s1_col_r;

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       out_err_r;

  logic [CMP_W-1:0] rb_ext, rb_sat, last_col;
  logic [BPP_W-1:0] bpp_sat, bpp_m1;
  logic [COL_W-1:0] col_eff, column_nxt;
  logic             first_eff;
  logic             in_acc, s1_adv;
  pngunf_item_t     item_nxt;
  logic [7:0]       prior_byte;
  logic [7:0]       raw_byte;
  logic             type_error;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_BYTES_W'(1);
      bpp_r       <= BPP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROW_BYTES:       row_bytes_r <= cfg_wdata[ROW_BYTES_W-1:0];
        REG_BYTES_PER_PIXEL: bpp_r       <= cfg_wdata[BPP_W-1:0];
      endcase
    end
  end

  assign rb_ext = CMP_W'(row_bytes_r);
  always_comb begin
    priority if (rb_ext == '0) begin
      rb_sat = CMP_W'(1);
    end else if (rb_ext > CMP_W'(MAX_ROW_BYTES)) begin
      rb_sat = CMP_W'(MAX_ROW_BYTES);
    end else begin
      rb_sat = rb_ext;
    end
  end
  assign last_col = rb_sat - CMP_W'(1);

  always_comb begin
    priority if (bpp_r == '0) begin
      bpp_sat = BPP_W'(1);
    end else if (bpp_r > BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_sat = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_sat = bpp_r;
    end
  end
  assign bpp_m1 = bpp_sat - BPP_W'(1);

  // handshakes
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // accept stage: row bookkeeping
  assign col_eff   = in_tuser[8] ? '0 : column_r;
  assign first_eff = in_tuser[8] | first_r;

  always_comb begin
    item_nxt.filt      = in_tdata;
    item_nxt.row_start = (col_eff == '0);
    item_nxt.ftype     = item_nxt.row_start ? in_tuser[7:0] : row_type_r;
    item_nxt.first_row = first_eff;
    item_nxt.has_left  = CMP_W'(col_eff) >= CMP_W'(bpp_sat);
    item_nxt.last      = CMP_W'(col_eff) >= last_col;
    column_nxt         = item_nxt.last ? '0 : col_eff + COL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      first_r    <= 1'b1;
      row_type_r <= FT_NONE;
    end else if (in_acc) begin
      column_r   <= column_nxt;
      first_r    <= first_eff && !item_nxt.last;
      row_type_r <= item_nxt.ftype;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= item_nxt;
      s1_col_r  <= col_eff;
    end
  end

  pngunf_row_mem #(
    .DEPTH  (MAX_ROW_BYTES),
    .ADDR_W (COL_W)
  ) u_row_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (col_eff),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (raw_byte),
    .rd_data (prior_byte)
  );

  pngunf_recon #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .HIST_W          (HIST_W)
  ) u_recon (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (s1_adv),
    .item       (s1_item_r),
    .prior_byte (prior_byte),
    .bpp_idx    (bpp_m1[HIST_W-1:0]),
    .raw_byte   (raw_byte),
    .type_error (type_error)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= raw_byte;
      out_last_r <= s1_item_r.last;
      out_err_r  <= type_error;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

// ----- rtl/core/pngunf_row_mem.sv -----
// previous-row byte store: one write port, one registered read port
// forwards a same-cycle write to the read; depends on nothing
module pngunf_row_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_q_r;
  logic [7:0] fwd_data_r;
  logic       fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // read and write of the same entry in one cycle: take the new byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;

endmodule

// ----- rtl/core/pngunf_recon.sv -----
// predictor stage: left and upper-left history, filter reconstruction
// uses pngunf_pkg for the item type and filter type codes
module pngunf_recon #(
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int HIST_W          = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  pngunf_pkg::pngunf_item_t   item,
  input  logic [7:0]                 prior_byte,
  input  logic [HIST_W-1:0]          bpp_idx,
  output logic [7:0]                 raw_byte,
  output logic                       type_error
);

  import pngunf_pkg::*;

  logic [7:0] left_r [MAX_PIXEL_BYTES];
  logic [7:0] up_r   [MAX_PIXEL_BYTES];
  logic [7:0] left_nxt [MAX_PIXEL_BYTES];
  logic [7:0] up_nxt   [MAX_PIXEL_BYTES];

  logic [7:0] a, b, c;
  logic [7:0] pa, pb;
  logic [8:0] sum_ab, c2, pc;
  logic [7:0] paeth;
  logic [7:0] avg;

  assign a = item.has_left ? left_r[bpp_idx] : 8'd0;
  assign b = item.first_row ? 8'd0 : prior_byte;
  assign c = (item.has_left && !item.first_row) ? up_r[bpp_idx] : 8'd0;

  assign sum_ab = {1'b0, a} + {1'b0, b};
  assign c2     = {c, 1'b0};
  assign pa     = (b > c) ? (b - c) : (c - b);
  assign pb     = (a > c) ? (a - c) : (c - a);
  assign pc     = (sum_ab > c2) ? (sum_ab - c2) : (c2 - sum_ab);
  assign avg    = sum_ab[8:1];

  // ties go to left, then up, then upper-left
  always_comb begin
    priority if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
      paeth = a;
    end else if ({1'b0, pb} <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  always_comb begin
    type_error = 1'b0;
    unique case (item.ftype)
      FT_NONE:  raw_byte = item.filt;
      FT_SUB:   raw_byte = item.filt + a;
      FT_UP:    raw_byte = item.filt + b;
      FT_AVG:   raw_byte = item.filt + avg;
      FT_PAETH: raw_byte = item.filt + paeth;
      default: begin
        raw_byte   = item.filt;
        type_error = 1'b1;
      end
    endcase
  end

  always_comb begin
    for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
      left_nxt[i] = item.row_start ? 8'd0 : left_r[i-1];
      up_nxt[i]   = item.row_start ? 8'd0 : up_r[i-1];
    end
    left_nxt[0] = raw_byte;
    up_nxt[0]   = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i] <= 8'd0;
        up_r[i]   <= 8'd0;
      end
    end else if (adv) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i] <= left_nxt[i];
        up_r[i]   <= up_nxt[i];
      end
    end
  end

endmodule

// ----- rtl/core/pngunf_checker.sv -----
// port-level checks for png_scanline_unfilter_top, attached by bind
// depends only on the top level's ports
module pngunf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // no result may appear in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an accepted byte passes s1, then out_tvalid must be high
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##2 out_tvalid)
    else $error("accepted byte did not reach the output stage");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind png_scanline_unfilter_top pngunf_checker u_pngunf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- sim/testbench.sv -----
// stream testbench for png_scanline_unfilter_top: directed and random filtered scanlines
// go in with random gaps, a local reconstruction predictor checks every output byte
// depends on pngunf_pkg and the rtl top level only
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pngunf_pkg::*;

  localparam int ROW_MAX = MAX_ROW_BYTES_DEF;
  localparam int PIX_MAX = MAX_PIXEL_BYTES_DEF;
  localparam longint CYCLE_LIMIT = 1000000;

  // directed rows of three bytes: one row per filter type plus two unknown types
  localparam logic [6:0][7:0] DIR_TYPES = {8'hff, 8'd5, FT_PAETH, FT_AVG, FT_UP, FT_SUB,
                                           FT_NONE};
  localparam logic [20:0][7:0] DIR_BYTES = {8'h00, 8'hff, 8'h00, 8'h66, 8'h55, 8'h44,
                                            8'hff, 8'hf0, 8'h10, 8'h03, 8'hff, 8'hff,
                                            8'h01, 8'hff, 8'h80, 8'h7f, 8'h01, 8'hff,
                                            8'h80, 8'hff, 8'h00};

  typedef struct packed {
    logic       start;
    logic [7:0] ftype;
    logic [7:0] filt;
  } scan_byte_t;

  typedef struct packed {
    logic [7:0] raw;
    logic       row_end;
    logic       type_err;
  } recon_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] filtered_byte
  logic [8:0]            in_tuser;   // [7:0] filter_type, [8] image_start
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // [7:0] raw_byte
  logic                  out_tlast;
  logic                  out_tuser;  // [0] type_error
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  png_scanline_unfilter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the block state and registers
  logic [7:0]  prev_row [ROW_MAX];
  logic [7:0]  left_hist [PIX_MAX];
  logic [7:0]  upleft_hist [PIX_MAX];
  int unsigned pred_col;
  bit          pred_first_row;
  logic [7:0]  pred_type;
  logic [12:0] reg_row_bytes;
  logic [3:0]  reg_bpp;

  scan_byte_t  filtered_pending [$];
  recon_t      raw_due [$];
  scan_byte_t  drv_byte;
  int unsigned n_queued, n_accepted, n_checked, n_errors;
  int unsigned in_gap, out_gap, in_gap_max, out_gap_max;
  int unsigned gen_col, gen_rb, hold_after;
  bit          in_taken, out_taken, hold_armed;
  longint      cycles;

  function automatic recon_t unfilter_byte(scan_byte_t sb);
    int unsigned rb, bpp, a, b, c, pa, pb, pc, pred, i;
    recon_t res;
    rb = (reg_row_bytes == 0) ? 1 : reg_row_bytes;
    if (rb > ROW_MAX) rb = ROW_MAX;
    bpp = (reg_bpp == 0) ? 1 : reg_bpp;
    if (bpp > PIX_MAX) bpp = PIX_MAX;
    if (sb.start) begin
      pred_col = 0;
      pred_first_row = 1;
    end
    if (pred_col >= ROW_MAX) pred_col = ROW_MAX - 1;
    if (pred_col == 0) begin
      pred_type = sb.ftype;
      for (i = 0; i < PIX_MAX; i++) begin
        left_hist[i] = 8'h00;
        upleft_hist[i] = 8'h00;
      end
    end
    // neighbors outside the image read as zero
    a = (pred_col >= bpp) ? left_hist[bpp-1] : 0;
    b = pred_first_row ? 0 : prev_row[pred_col];
    c = (pred_col >= bpp && !pred_first_row) ? upleft_hist[bpp-1] : 0;
    res.type_err = 1'b0;
    case (pred_type)
      FT_NONE:  pred = 0;
      FT_SUB:   pred = a;
      FT_UP:    pred = b;
      FT_AVG:   pred = (a + b) >> 1;
      FT_PAETH: begin
        pa = (b > c) ? b - c : c - b;
        pb = (a > c) ? a - c : c - a;
        pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
        // ties go to left, then up, then upper-left
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc) pred = b;
        else pred = c;
      end
      default: begin
        pred = 0;
        res.type_err = 1'b1;
      end
    endcase
    res.raw = 8'(sb.filt + pred);
    for (i = PIX_MAX - 1; i > 0; i--) begin
      left_hist[i] = left_hist[i-1];
      upleft_hist[i] = upleft_hist[i-1];
    end
    left_hist[0] = res.raw;
    upleft_hist[0] = 8'(b);
    prev_row[pred_col] = res.raw;
    res.row_end = (pred_col >= rb - 1);
    if (res.row_end) begin
      pred_col = 0;
      pred_first_row = 0;
    end else begin
      pred_col++;
    end
    return res;
  endfunction

  task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
    n_errors++;
    $error("%s: expected %0h, actual %0h", field, want, got);
  endtask

  task automatic queue_byte(logic [7:0] filt, logic [7:0] ftype, logic start);
    scan_byte_t sb;
    sb.start = start;
    sb.ftype = ftype;
    sb.filt = filt;
    filtered_pending.push_back(sb);
    n_queued++;
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == REG_ROW_BYTES) reg_row_bytes = val;
    else reg_bpp = val[3:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || raw_due.size() != 0) @(posedge clk);
  endtask

  // rows with random types and content; each run opens a new image, noise adds stray
  // image starts in the middle of rows
  task automatic queue_random_bytes(int unsigned count, bit noise);
    logic [7:0] ft, fb;
    bit st;
    int unsigned k;
    for (k = 0; k < count; k++) begin
      st = (k == 0);
      if (noise && $urandom_range(0, 39) == 0) st = 1;
      if (st) gen_col = 0;
      if (gen_col == 0 && $urandom_range(0, 9) < 7) ft = 8'($urandom_range(0, 4));
      else ft = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0:       fb = 8'h00;
        1:       fb = 8'hff;
        default: fb = 8'($urandom_range(0, 255));
      endcase
      queue_byte(fb, ft, st);
      gen_col = (gen_col + 1 >= gen_rb) ? 0 : gen_col + 1;
    end
  endtask

  task automatic run_phase(logic [12:0] rb_val, logic [12:0] bpp_val, int unsigned count,
                           bit noise);
    wait_drained();
    in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
    out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
    write_reg(REG_ROW_BYTES, rb_val);
    write_reg(REG_BYTES_PER_PIXEL, bpp_val);
    gen_rb = (rb_val == 0) ? 1 : ((rb_val > ROW_MAX) ? ROW_MAX : rb_val);
    queue_random_bytes(count, noise);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // input side: accept at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      raw_due.push_back(unfilter_byte(drv_byte));
      n_accepted++;
      in_taken = 1;
    end
  end

  always @(negedge clk) begin : drive_in
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_taken) begin
        in_taken = 0;
        nxt_valid = 1'b0;
        in_gap = $urandom_range(0, in_gap_max);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (filtered_pending.size() > 0) begin
          drv_byte = filtered_pending.pop_front();
          in_tdata <= drv_byte.filt;
          in_tuser <= {drv_byte.start, drv_byte.ftype};
          nxt_valid = 1'b1;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // output side: check each transaction against the oldest predicted byte
  always @(posedge clk) begin : check_out
    recon_t want;
    if (rst_n && out_tvalid && out_tready) begin
      out_taken = 1;
      n_checked++;
      if (raw_due.size() == 0) begin
        n_errors++;
        $error("unexpected result: raw_byte %0h", out_tdata);
      end else begin
        want = raw_due.pop_front();
        if (out_tdata !== want.raw) flag_mismatch("raw_byte", want.raw, out_tdata);
        if (out_tlast !== want.row_end) flag_mismatch("row_end", want.row_end, out_tlast);
        if (out_tuser !== want.type_err) flag_mismatch("type_error", want.type_err, out_tuser);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 0;
        out_gap = $urandom_range(0, out_gap_max);
        // one long hold so the block backs up into its input
        if (hold_armed && n_checked >= hold_after) begin
          hold_armed = 0;
          out_gap = 400;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned random_items, cnt, row, col, i;
    logic [12:0] rbv, bv;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    for (i = 0; i < ROW_MAX; i++) prev_row[i] = 8'h00;
    for (i = 0; i < PIX_MAX; i++) begin
      left_hist[i] = 8'h00;
      upleft_hist[i] = 8'h00;
    end
    pred_col = 0;
    pred_first_row = 1;
    pred_type = FT_NONE;
    reg_row_bytes = 13'd1;
    reg_bpp = 4'd1;
    in_gap_max = 14;
    out_gap_max = 14;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // register defaults: one-byte rows, first byte without image start
    queue_byte(8'h12, FT_SUB, 1'b0);
    queue_byte(8'hf0, FT_UP, 1'b0);
    wait_drained();

    // every filter type and two unknown ones, three-byte rows, two-byte pixels
    write_reg(REG_ROW_BYTES, 13'd3);
    write_reg(REG_BYTES_PER_PIXEL, 13'd2);
    for (row = 0; row < 7; row++) begin
      for (col = 0; col < 3; col++) begin
        queue_byte(DIR_BYTES[row*3+col], (col == 0) ? DIR_TYPES[row] : DIR_TYPES[6-row],
                   row == 0 && col == 0);
      end
    end
    wait_drained();

    // row length lowered in the middle of a row ends it at the next byte
    write_reg(REG_ROW_BYTES, 13'd5);
    write_reg(REG_BYTES_PER_PIXEL, 13'd1);
    queue_byte(8'h40, FT_SUB, 1'b1);
    queue_byte(8'h08, FT_SUB, 1'b0);
    wait_drained();
    write_reg(REG_ROW_BYTES, 13'd2);
    queue_byte(8'h21, FT_NONE, 1'b0);
    queue_byte(8'h05, FT_UP, 1'b0);
    queue_byte(8'h06, FT_AVG, 1'b0);

    // zero registers, widest pixel, ignored upper bits of the pixel register
    run_phase(13'd0, 13'd0, 12, 1);
    run_phase(13'd1, 13'd8, 30, 1);
    run_phase(13'd7, 13'h1f05, 40, 1);

    // saturated row length: the run stays inside the first row
    run_phase(13'h1fff, 13'd15, 60, 0);
    random_items = n_queued;
    hold_after = n_checked + 64;
    hold_armed = 1;

    while (random_items < 1050) begin
      if ($urandom_range(0, 7) == 0) rbv = 13'($urandom_range(0, 300));
      else rbv = 13'($urandom_range(1, 24));
      if ($urandom_range(0, 1) == 1) bv = 13'($urandom_range(0, 8191));
      else bv = 13'($urandom_range(0, 15));
      cnt = $urandom_range(20, 120);
      run_phase(rbv, bv, cnt, 1);
      random_items += cnt;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (n_errors == 0 && raw_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
